// File: rtl/core/vrtc_pkg.sv
package vrtc_pkg;

    localparam int OP_W   = 3;
    localparam int ADDR_W = 64;
    localparam int CNT_W  = 32;
    localparam int SIZE_W = 64;
    localparam int HALF_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INS_STATIC = 3'd0,
        OP_INS_HEAP   = 3'd1,
        OP_REMOVE     = 3'd2,
        OP_CHK_ACCESS = 3'd3,
        OP_CHK_FREE   = 3'd4,
        OP_FREE       = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic clr_en;
        logic commit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

// File: rtl/core/vrtc_ctrl.sv
module vrtc_ctrl
    import vrtc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  status_t          status,
    output cmd_t             cmd,
    output logic [IDX_W-1:0] idx
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_CLEAR: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                    idx_next   = '0;
                end
            end
            ST_IDLE: begin
                idx_next = '0;
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                    idx_next   = '0;
                end
            end
            ST_DRAIN: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold until the previous result has left the output register
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                idx_next   = '0;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_COMMIT: begin
                cmd.commit = !status.out_busy;
            end
            default: begin
            end
        endcase
    end

    assign idx = idx_reg;

    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.rd_en, cmd.clr_en, cmd.commit}))
        else $error("controller issued overlapping commands");

    a_scan_from_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (cmd.rd_en && idx == '0))
        else $error("scan did not start at entry zero");

    a_last_read_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_en && idx == LAST_IDX) |=> (state_reg == ST_DRAIN))
        else $error("scan did not end after the last entry");

endmodule

// File: rtl/core/vrtc_dp.sv
module vrtc_dp
    import vrtc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    input  logic [IDX_W-1:0]  idx,
    output status_t           status,
    input  logic [OP_W-1:0]   s_op,
    input  logic [ADDR_W-1:0] s_address,
    input  logic [CNT_W-1:0]  s_elem_count,
    input  logic [SIZE_W-1:0] s_byte_size,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_is_valid,
    output logic              m_table_full
);

    // transaction fields
    logic [OP_W-1:0]   op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SIZE_W-1:0] size_reg;

    // static length, two partial products
    logic [2*HALF_W-1:0] prod_lo_reg;
    logic [HALF_W-1:0]   prod_hi_reg;
    logic [SIZE_W-1:0]   len_reg;
    logic [ADDR_W:0]     reach_reg;

    // region table
    logic              used_mem [TABLE_ENTRIES];
    logic [ADDR_W-1:0] base_mem [TABLE_ENTRIES];
    logic [SIZE_W-1:0] len_mem  [TABLE_ENTRIES];
    logic              heap_mem [TABLE_ENTRIES];

    logic              rd_vld_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rd_used_reg;
    logic [ADDR_W-1:0] rd_base_reg;
    logic [SIZE_W-1:0] rd_len_reg;
    logic              rd_heap_reg;

    // scan trackers
    logic              ex_found_reg;
    logic [IDX_W-1:0]  ex_idx_reg;
    logic [SIZE_W-1:0] ex_len_reg;
    logic              ex_heap_reg;
    logic              fr_found_reg;
    logic [IDX_W-1:0]  fr_idx_reg;
    logic              pd_found_reg;
    logic [ADDR_W-1:0] pd_base_reg;
    logic [ADDR_W:0]   pd_end_reg;

    logic              m_valid_reg;
    logic              m_is_valid_reg;
    logic              m_table_full_reg;

    logic              hit_used, ex_hit, fr_hit, pd_hit;
    logic [ADDR_W:0]   rd_end;

    logic              res_valid, res_full;
    logic              ins_we, rel_we;
    logic [IDX_W-1:0]  tgt_idx;
    logic              used_we, used_wd, data_we;
    logic [IDX_W-1:0]  wr_idx;
    logic [SIZE_W-1:0] wr_len;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_op;
            addr_reg  <= s_address;
            count_reg <= s_elem_count;
            size_reg  <= s_byte_size;
        end
        prod_lo_reg <= size_reg[HALF_W-1:0] * count_reg;
        prod_hi_reg <= HALF_W'(size_reg[SIZE_W-1:HALF_W] * count_reg);
        len_reg     <= prod_lo_reg + {prod_hi_reg, {HALF_W{1'b0}}};
        reach_reg   <= {1'b0, addr_reg} + {1'b0, size_reg};
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (used_we) begin
            used_mem[wr_idx] <= used_wd;
        end
        if (data_we) begin
            base_mem[wr_idx] <= addr_reg;
            len_mem[wr_idx]  <= wr_len;
            heap_mem[wr_idx] <= (op_reg == OP_INS_HEAP);
        end
        if (cmd.rd_en) begin
            rd_used_reg <= used_mem[idx];
            rd_base_reg <= base_mem[idx];
            rd_len_reg  <= len_mem[idx];
            rd_heap_reg <= heap_mem[idx];
        end
        rd_idx_reg <= idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
        end
    end

    assign hit_used = rd_vld_reg && rd_used_reg;
    assign ex_hit   = hit_used && !ex_found_reg && (rd_base_reg == addr_reg);
    assign fr_hit   = rd_vld_reg && !rd_used_reg && !fr_found_reg;
    assign pd_hit   = hit_used && (rd_base_reg < addr_reg)
                      && (!pd_found_reg || rd_base_reg > pd_base_reg);
    assign rd_end   = {1'b0, rd_base_reg} + {1'b0, rd_len_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load) begin
            ex_found_reg <= 1'b0;
            fr_found_reg <= 1'b0;
            pd_found_reg <= 1'b0;
        end else begin
            if (ex_hit) begin
                ex_found_reg <= 1'b1;
            end
            if (fr_hit) begin
                fr_found_reg <= 1'b1;
            end
            if (pd_hit) begin
                pd_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_hit) begin
            ex_idx_reg  <= rd_idx_reg;
            ex_len_reg  <= rd_len_reg;
            ex_heap_reg <= rd_heap_reg;
        end
        if (fr_hit) begin
            fr_idx_reg <= rd_idx_reg;
        end
        if (pd_hit) begin
            pd_base_reg <= rd_base_reg;
            pd_end_reg  <= rd_end;
        end
    end

    // operation result, valid once the scan has drained
    always_comb begin
        res_valid = 1'b0;
        res_full  = 1'b0;
        ins_we    = 1'b0;
        rel_we    = 1'b0;
        tgt_idx   = ex_idx_reg;
        case (op_reg)
            OP_INS_STATIC, OP_INS_HEAP: begin
                if (ex_found_reg) begin
                    res_valid = 1'b1;
                    ins_we    = 1'b1;
                end else if (fr_found_reg) begin
                    res_valid = 1'b1;
                    ins_we    = 1'b1;
                    tgt_idx   = fr_idx_reg;
                end else begin
                    res_full = 1'b1;
                end
            end
            OP_REMOVE: begin
                res_valid = ex_found_reg;
                rel_we    = ex_found_reg;
            end
            OP_CHK_ACCESS: begin
                // exact base decides alone; otherwise the nearest region below
                if (ex_found_reg) begin
                    res_valid = (size_reg <= ex_len_reg);
                end else begin
                    res_valid = pd_found_reg && ({1'b0, addr_reg} <= pd_end_reg)
                                && (reach_reg <= pd_end_reg);
                end
            end
            OP_CHK_FREE: begin
                res_valid = ex_found_reg && ex_heap_reg;
            end
            OP_FREE: begin
                res_valid = ex_found_reg && ex_heap_reg;
                rel_we    = ex_found_reg && ex_heap_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        used_we = cmd.clr_en || (cmd.commit && (ins_we || rel_we));
        used_wd = !cmd.clr_en && ins_we;
        data_we = cmd.commit && ins_we;
        wr_idx  = cmd.clr_en ? idx : tgt_idx;
        wr_len  = (op_reg == OP_INS_STATIC) ? len_reg : size_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_is_valid_reg   <= res_valid;
            m_table_full_reg <= res_full;
        end
    end

    assign status.out_busy = m_valid_reg && !m_ready;
    assign m_valid         = m_valid_reg;
    assign m_is_valid      = m_is_valid_reg;
    assign m_table_full    = m_table_full_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_valid_reg && !m_ready))
        else $error("result committed over an untaken transaction");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("committed result not presented");

    a_full_not_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_table_full_reg) |-> !m_is_valid_reg)
        else $error("dropped insert reported as done");

endmodule

// File: rtl/core/valid_region_table_checker.sv
// Region table with bounds checks.
// Input channel (s_valid/s_ready): one transaction carries s_op, s_address,
// s_elem_count and s_byte_size. Ops: insert static, insert heap, remove,
// check access, check free, free.
// Result channel (m_valid/m_ready): exactly one transaction per input,
// m_is_valid and m_table_full, in input order.
// Each operation scans the whole table through the single read port of the
// region memory, one entry per cycle. The result is registered after the scan
// has drained, and a new input is taken only once the previous operation has
// committed.
// After aresetn is released the table is emptied by a clearing pass over every
// entry, during which s_ready stays low.
// s_ready is high whenever no operation is in flight, even while the previous
// result waits in the output register. If m_ready stays low the finished
// operation holds its table update and result until the output register
// frees, and no new input is taken meanwhile.
module valid_region_table_checker
    import vrtc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [ADDR_W-1:0] s_address,
    input  logic [CNT_W-1:0]  s_elem_count,
    input  logic [SIZE_W-1:0] s_byte_size,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_is_valid,
    output logic              m_table_full
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    cmd_t             cmd;
    status_t          status;
    logic [IDX_W-1:0] idx;

    vrtc_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd),
        .idx     (idx)
    );

    vrtc_dp #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .idx          (idx),
        .status       (status),
        .s_op         (s_op),
        .s_address    (s_address),
        .s_elem_count (s_elem_count),
        .s_byte_size  (s_byte_size),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_valid   (m_is_valid),
        .m_table_full (m_table_full)
    );

endmodule
